### hdl/vid_pkg.sv
// Shared constants, types and hash function for the vertex index deduplicator.
`timescale 1ns / 1ps
`default_nettype none
package vid_pkg;
	localparam int TABLE_ENTRIES   = 4096;
	localparam int IDX_BITS        = 16;
	localparam int FIELD_BITS      = 16;
	localparam int OUT_VERTEX_BITS = 12;
	localparam int VNUM_BITS       = $clog2(TABLE_ENTRIES);
	localparam int CNT_BITS        = VNUM_BITS + 1;
	localparam int SLOT_BITS       = VNUM_BITS + 1;
	localparam int SLOTS           = 2 * TABLE_ENTRIES;
	localparam int EPOCH_BITS      = 8;
	localparam int KEY_BITS        = 3 * IDX_BITS;

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [VNUM_BITS-1:0]  vnum_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [EPOCH_BITS-1:0] epoch_t;

	typedef struct packed {
		epoch_t tag;
		idx_t   pos;
		idx_t   tex;
		idx_t   nrm;
		vnum_t  vnum;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef struct packed {
		vnum_t vnum;
		logic  is_new;
		logic  overflow;
		idx_t  pos;
		idx_t  tex;
		idx_t  nrm;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_READ,
		ST_CMP
	} vid_state_t;

	function automatic slot_t vid_hash(input idx_t p, input idx_t t, input idx_t n);
		logic [KEY_BITS-1:0] k;
		slot_t h;
		k = {p, t, n};
		h = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ k[i];
		end
		return h;
	endfunction
endpackage
`default_nettype wire

### hdl/vid_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

### hdl/vid_ctrl.sv
// Hash probe sequencer: lookup, insert, epoch handling and clearing sweeps.
`timescale 1ns / 1ps
`default_nettype none
module vid_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire logic            first_of_mesh,
	input  wire vid_pkg::idx_t   pos_in,
	input  wire vid_pkg::idx_t   tex_in,
	input  wire vid_pkg::idx_t   nrm_in,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output vid_pkg::result_t     res
);
	import vid_pkg::*;

	vid_state_t state_q, state_d;
	epoch_t     epoch_q, epoch_d;
	cnt_t       count_q, count_d;
	slot_t      sweep_q, sweep_d;
	slot_t      slot_q, slot_d;
	idx_t       pos_q, tex_q, nrm_q;
	logic       capture;

	logic                  ram_en, ram_we;
	slot_t                 ram_addr;
	entry_t                wr_entry, rd_entry;
	logic [ENTRY_BITS-1:0] ram_rdata;

	logic occupied, hit;

	vid_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_entry),
		.rdata(ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);
	assign occupied = rd_entry.tag == epoch_q;
	assign hit = occupied && rd_entry.pos == pos_q && rd_entry.tex == tex_q
		&& rd_entry.nrm == nrm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			epoch_q <= '0;
			count_q <= '0;
			sweep_q <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			epoch_q <= epoch_d;
			count_q <= count_d;
			sweep_q <= sweep_d;
			slot_q  <= slot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			pos_q <= pos_in;
			tex_q <= tex_in;
			nrm_q <= nrm_in;
		end
	end

	always_comb begin
		state_d   = state_q;
		epoch_d   = epoch_q;
		count_d   = count_q;
		sweep_d   = sweep_q;
		slot_d    = slot_q;
		capture   = 1'b0;
		req_stall = 1'b1;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = slot_q;
		wr_entry  = '0;
		res_valid = 1'b0;
		res.vnum     = '0;
		res.is_new   = 1'b0;
		res.overflow = 1'b0;
		res.pos      = pos_q;
		res.tex      = tex_q;
		res.nrm      = nrm_q;
		case (state_q)
			ST_CLEAR, ST_WRAP: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = sweep_q;
				sweep_d  = sweep_q + SLOT_BITS'(1);
				if (sweep_q == '1) begin
					epoch_d = EPOCH_BITS'(1);
					state_d = (state_q == ST_CLEAR) ? ST_IDLE : ST_READ;
				end
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					capture = 1'b1;
					slot_d  = vid_hash(pos_in, tex_in, nrm_in);
					if (first_of_mesh) begin
						count_d = '0;
					end
					if (first_of_mesh && epoch_q == '1) begin
						sweep_d = '0;
						state_d = ST_WRAP;
					end else begin
						if (first_of_mesh) begin
							epoch_d = epoch_q + EPOCH_BITS'(1);
						end
						ram_en   = 1'b1;
						ram_addr = vid_hash(pos_in, tex_in, nrm_in);
						state_d  = ST_CMP;
					end
				end
			end
			ST_READ: begin
				ram_en  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (occupied && !hit) begin
					ram_en   = 1'b1;
					ram_addr = slot_q + SLOT_BITS'(1);
					slot_d   = slot_q + SLOT_BITS'(1);
				end else begin
					res_valid = 1'b1;
					if (hit) begin
						res.vnum = rd_entry.vnum;
					end else if (count_q != CNT_BITS'(TABLE_ENTRIES)) begin
						res.vnum   = count_q[VNUM_BITS-1:0];
						res.is_new = 1'b1;
					end else begin
						res.overflow = 1'b1;
					end
					if (!res_stall) begin
						if (res.is_new) begin
							ram_en        = 1'b1;
							ram_we        = 1'b1;
							wr_entry.tag  = epoch_q;
							wr_entry.pos  = pos_q;
							wr_entry.tex  = tex_q;
							wr_entry.nrm  = nrm_q;
							wr_entry.vnum = count_q[VNUM_BITS-1:0];
							count_d       = count_q + CNT_BITS'(1);
						end
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
				sweep_d = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

### hdl/vertex_index_deduplicator.sv
// Top level of the vertex index deduplicator with its output register.
// Each request is one face corner; the block answers with its vertex number,
// numbered in order of first appearance since the last first_of_mesh. Corners
// live in an open-addressed hash table of 2 x TABLE_ENTRIES slots in one RAM,
// probed linearly. A corner reads its hashed slot and then each next slot
// until one hits or is free; the probe loop on the single RAM port sets the
// rate. Slots are tagged with a mesh epoch so a new mesh starts at once;
// after reset a clearing pass over all 2 x TABLE_ENTRIES slots runs before
// requests are taken, and once every 255 meshes, when the epoch tag wraps,
// one runs before the first corner of the new mesh is looked up. The output
// register lets the next request be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module vertex_index_deduplicator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic                            first_of_mesh,
	input  wire logic [15:0]                     position_index,
	input  wire logic [15:0]                     texcoord_index,
	input  wire logic [15:0]                     normal_index,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output logic [vid_pkg::OUT_VERTEX_BITS-1:0]  vertex_index,
	output logic                                 is_new,
	output logic                                 overflow,
	output logic [vid_pkg::FIELD_BITS-1:0]       out_position_index,
	output logic [vid_pkg::FIELD_BITS-1:0]       out_texcoord_index,
	output logic [vid_pkg::FIELD_BITS-1:0]       out_normal_index
);
	import vid_pkg::*;

	logic    res_valid, res_stall, load;
	result_t res, res_q;
	logic    rsp_valid_q;

	vid_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.first_of_mesh(first_of_mesh),
		.pos_in       (IDX_BITS'(position_index)),
		.tex_in       (IDX_BITS'(texcoord_index)),
		.nrm_in       (IDX_BITS'(normal_index)),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res)
	);

	assign res_stall = rsp_valid_q && rsp_stall;
	assign load      = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign vertex_index       = OUT_VERTEX_BITS'(res_q.vnum);
	assign is_new             = res_q.is_new;
	assign overflow           = res_q.overflow;
	assign out_position_index = FIELD_BITS'(res_q.pos);
	assign out_texcoord_index = FIELD_BITS'(res_q.tex);
	assign out_normal_index   = FIELD_BITS'(res_q.nrm);
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for vertex_index_deduplicator: random and directed corners against a predictor.
`timescale 1ns / 1ps
module tb_top;
	typedef struct {
		logic        first;
		logic [15:0] pos;
		logic [15:0] tex;
		logic [15:0] nrm;
	} corner_req_t;

	typedef logic [3*16-1:0] corner_key_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic first_of_mesh = 1'b0;
	logic [15:0] position_index = '0;
	logic [15:0] texcoord_index = '0;
	logic [15:0] normal_index = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [vid_pkg::OUT_VERTEX_BITS-1:0] vertex_index;
	logic is_new;
	logic overflow;
	logic [vid_pkg::FIELD_BITS-1:0] out_position_index;
	logic [vid_pkg::FIELD_BITS-1:0] out_texcoord_index;
	logic [vid_pkg::FIELD_BITS-1:0] out_normal_index;

	corner_req_t pending_corners[$];
	vid_pkg::result_t awaited_vertices[$];

	// predictor state: corners of the current mesh and their vertex numbers
	int unsigned vertex_of[bit [vid_pkg::KEY_BITS-1:0]];
	int unsigned stored_count = 0;

	int unsigned mismatch_count = 0;
	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;
	int unsigned req_gap_left = 0;
	int unsigned rsp_hold_left = 0;
	int unsigned sent_count = 0;
	int unsigned taken_results = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;

	vertex_index_deduplicator u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic vid_pkg::result_t assign_vertex(input logic first,
			input logic [15:0] p_in, input logic [15:0] t_in, input logic [15:0] n_in);
		vid_pkg::result_t r;
		vid_pkg::idx_t p;
		vid_pkg::idx_t t;
		vid_pkg::idx_t n;
		bit [vid_pkg::KEY_BITS-1:0] key;
		p = vid_pkg::idx_t'(p_in);
		t = vid_pkg::idx_t'(t_in);
		n = vid_pkg::idx_t'(n_in);
		key = {p, t, n};
		if (first) begin
			vertex_of.delete();
			stored_count = 0;
		end
		r = '0;
		r.pos = p;
		r.tex = t;
		r.nrm = n;
		if (vertex_of.exists(key)) begin
			r.vnum = vid_pkg::vnum_t'(vertex_of[key]);
		end else if (stored_count < vid_pkg::TABLE_ENTRIES) begin
			r.vnum = vid_pkg::vnum_t'(stored_count);
			r.is_new = 1'b1;
			vertex_of[key] = stored_count;
			stored_count++;
		end else begin
			r.overflow = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < 100)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what,
				got, want);
		mismatch_count++;
	endtask

	task automatic add_corner(input logic first, input corner_key_t key);
		corner_req_t c;
		c.first = first;
		c.pos = key[47:32];
		c.tex = key[31:16];
		c.nrm = key[15:0];
		pending_corners.insert(pending_corners.size(), c);
	endtask

	function automatic logic [15:0] rand_idx();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 7));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// request side
	always @(negedge clk) begin : drive_requests
		corner_req_t c;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (req_gap_left > 0) begin
				req_valid <= 1'b0;
				req_gap_left <= req_gap_left - 1;
			end else if (pending_corners.size() > 0) begin
				c = pending_corners.pop_front();
				req_valid <= 1'b1;
				first_of_mesh <= c.first;
				position_index <= c.pos;
				texcoord_index <= c.tex;
				normal_index <= c.nrm;
				sent_count++;
				if (sent_count % 150 == 0)
					req_calm = ($urandom_range(0, 3) == 0);
				req_gap_left <= draw_wait(req_calm);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side
	always @(negedge clk) begin : drive_stall
		int unsigned hold;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (rsp_taken) begin
			if (taken_results % 128 == 0)
				rsp_calm = ($urandom_range(0, 3) == 0);
			hold = draw_wait(rsp_calm);
			rsp_stall <= (hold > 0);
			rsp_hold_left <= (hold > 0) ? hold - 1 : 0;
		end else if (rsp_hold_left > 0) begin
			rsp_stall <= 1'b1;
			if (rsp_valid)
				rsp_hold_left <= rsp_hold_left - 1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : sample_ports
		vid_pkg::result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			rsp_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			rsp_taken <= rsp_valid && !rsp_stall;
			if (req_valid && !req_stall)
				awaited_vertices.insert(awaited_vertices.size(),
					assign_vertex(first_of_mesh, position_index, texcoord_index,
					normal_index));
			if (rsp_valid && !rsp_stall) begin
				taken_results++;
				if (awaited_vertices.size() == 0) begin
					report_mismatch("unexpected result", 16'(vertex_index), 16'h0);
				end else begin
					want = awaited_vertices.pop_front();
					if (vertex_index !== want.vnum)
						report_mismatch("vertex_index", 16'(vertex_index), 16'(want.vnum));
					if (is_new !== want.is_new)
						report_mismatch("is_new", 16'(is_new), 16'(want.is_new));
					if (overflow !== want.overflow)
						report_mismatch("overflow", 16'(overflow), 16'(want.overflow));
					if (out_position_index !== want.pos)
						report_mismatch("out_position_index", out_position_index, want.pos);
					if (out_texcoord_index !== want.tex)
						report_mismatch("out_texcoord_index", out_texcoord_index, want.tex);
					if (out_normal_index !== want.nrm)
						report_mismatch("out_normal_index", out_normal_index, want.nrm);
				end
			end
		end
	end

	initial begin : stimulus
		corner_key_t mesh_corners[$];
		corner_key_t prev_mesh[$];
		corner_key_t key;
		int unsigned random_count;
		int unsigned mesh_count;
		int unsigned len;
		int unsigned sel;
		int unsigned j;
		logic first;

		// directed: extremes, hits, hash aliases, mesh restarts
		add_corner(1'b1, {16'h0000, 16'h0000, 16'h0000});
		add_corner(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'h0000});
		add_corner(1'b0, {16'hFFFF, 16'h0000, 16'h0000});
		add_corner(1'b0, {16'h0000, 16'hFFFF, 16'h0000});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'hFFFF});
		add_corner(1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'h2001});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'h2001});
		add_corner(1'b0, {16'h8000, 16'h7FFF, 16'h5555});
		add_corner(1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'h0000});
		add_corner(1'b1, {16'h0000, 16'h0000, 16'h0000});
		add_corner(1'b0, {16'h0000, 16'h0000, 16'h0000});
		add_corner(1'b0, {16'hAAAA, 16'h5555, 16'hAAAA});

		// random meshes: mostly short, with repeats, aliases and stale corners;
		// enough mesh starts to run the epoch through its wrap
		random_count = 0;
		mesh_count = 0;
		while (random_count < 1435) begin
			len = ($urandom_range(0, 39) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 6);
			mesh_corners.delete();
			for (int i = 0; i < len; i++) begin
				first = (i == 0);
				sel = $urandom_range(0, 99);
				if (i > 0 && sel < 40) begin
					key = mesh_corners[$urandom_range(0, mesh_corners.size() - 1)];
				end else if (i > 0 && sel < 55) begin
					key = mesh_corners[$urandom_range(0, mesh_corners.size() - 1)];
					j = $urandom_range(0, 34);
					key[j] = ~key[j];
					key[j+13] = ~key[j+13];
				end else if (sel < 65 && prev_mesh.size() > 0) begin
					key = prev_mesh[$urandom_range(0, prev_mesh.size() - 1)];
				end else begin
					key = {rand_idx(), rand_idx(), rand_idx()};
				end
				if (sel >= 97)
					first = 1'b1;
				add_corner(first, key);
				mesh_corners.insert(mesh_corners.size(), key);
				random_count++;
			end
			prev_mesh = mesh_corners;
			mesh_count++;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_corners.size() != 0 || req_valid || awaited_vertices.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && awaited_vertices.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Verification failed");
		$finish;
	end
endmodule

### files.f
hdl/vid_pkg.sv
hdl/vid_ram.sv
hdl/vid_ctrl.sv
hdl/vertex_index_deduplicator.sv
tb/tb_top.sv
